// ===== hw/rtl/bset_pkg.sv =====
package bset_pkg;

    localparam int WORD_WIDTH_DEF    = 64;
    localparam int WORDS_PER_SET_DEF = 16;
    localparam int SET_COUNT_DEF     = 4;

    localparam int ACTION_W = 4;
    localparam int INDEX_W  = 11;
    localparam int CFG_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_TEST        = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT      = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE      = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR       = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_BELOW = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_COUNT       = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_EMPTY       = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_UNION       = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_INTERSECT   = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_DIFFERENCE  = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_DISJOINT    = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_EQUAL       = 4'd11;
    localparam logic [ACTION_W-1:0] ACT_ITER_START  = 4'd12;
    localparam logic [ACTION_W-1:0] ACT_ITER_NEXT   = 4'd13;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request and clear the accumulators
        logic clr_step;  // zero-out pass after reset: clear word at the init pointer
        logic rd;        // issue a read of the word at the sweep position
        logic proc;      // read data of the previous read is valid this cycle
        logic advance;   // step the sweep position
        logic finish;    // emit the result
    } bset_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic last_word; // sweep position (init pointer in the clearing pass) is at the last word to visit
        logic scan_hit;  // iterator scan found a member in the processed word
        logic is_iter;   // request is iter_next
        logic no_sweep;  // request needs no memory access
    } bset_sts_t;

endpackage

// ===== hw/rtl/bset_ctrl.sv =====
module bset_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bset_pkg::bset_sts_t  sts,
    output bset_pkg::bset_cmd_t  cmd,
    output logic                 busy
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_PROC = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                cmd.advance  = 1'b1;
                if (sts.last_word)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = sts.no_sweep ? S_DONE : S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PROC;
            end
            S_PROC:
            begin
                // Each word is read in S_RD, then modified or accumulated here.
                cmd.proc = 1'b1;
                if (sts.last_word || (sts.is_iter && sts.scan_hit))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bset_dp.sv =====
module bset_dp #(
    parameter int WORD_WIDTH    = bset_pkg::WORD_WIDTH_DEF,
    parameter int WORDS_PER_SET = bset_pkg::WORDS_PER_SET_DEF,
    parameter int SET_COUNT     = bset_pkg::SET_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bset_pkg::bset_cmd_t           cmd,
    output bset_pkg::bset_sts_t           sts,
    input  logic                          cfg_we,
    input  logic [bset_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [bset_pkg::ACTION_W-1:0] action,
    input  logic [1:0]                    set_a,
    input  logic [1:0]                    set_b,
    input  logic [bset_pkg::INDEX_W-1:0]  bit_index,
    output logic                          done,
    output logic                          flag,
    output logic [bset_pkg::INDEX_W-1:0]  value,
    output logic                          error
);

    localparam int BW    = $clog2(WORD_WIDTH);
    localparam int WW    = (WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1;
    localparam int SW    = $clog2(SET_COUNT);
    localparam int DEPTH = SET_COUNT * WORDS_PER_SET;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = bset_pkg::INDEX_W;
    localparam int CW    = BW + 1;

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    logic [bset_pkg::CFG_W-1:0]    active_reg;
    logic [bset_pkg::ACTION_W-1:0] act_reg;
    logic [SW-1:0]                 sa_reg, sb_reg, iset_reg;
    logic [IW-1:0]                 idx_reg, ipos_reg;
    logic [WW-1:0]                 w_reg;
    logic [AW-1:0]                 init_reg;
    logic [WORD_WIDTH-1:0]         da_reg, db_reg;
    logic                          flag_reg, err_reg, done_reg;
    logic [IW-1:0]                 val_reg;

    // Live word count and size.
    logic [IW-1:0] nw, size, last_w;
    always_comb
    begin
        if (active_reg == '0)
        begin
            nw = IW'(1);
        end
        else if (32'(active_reg) > WORDS_PER_SET)
        begin
            nw = IW'(WORDS_PER_SET);
        end
        else
        begin
            nw = IW'(active_reg);
        end
        size   = IW'(nw * IW'(WORD_WIDTH));
        last_w = nw - IW'(1);
    end

    logic [IW-1:0] wi, pwi;
    logic [BW-1:0] bi, pbi;
    assign wi  = idx_reg >> BW;
    assign bi  = idx_reg[BW-1:0];
    assign pwi = ipos_reg >> BW;
    assign pbi = ipos_reg[BW-1:0];

    logic is_bit, is_cb, is_iter, is_pair, is_write;
    assign is_bit  = (act_reg == bset_pkg::ACT_TEST) || (act_reg == bset_pkg::ACT_INSERT)
                     || (act_reg == bset_pkg::ACT_DELETE);
    assign is_cb   = (act_reg == bset_pkg::ACT_CLEAR_BELOW);
    assign is_iter = (act_reg == bset_pkg::ACT_ITER_NEXT);
    assign is_pair = (act_reg == bset_pkg::ACT_UNION) || (act_reg == bset_pkg::ACT_INTERSECT)
                     || (act_reg == bset_pkg::ACT_DIFFERENCE)
                     || (act_reg == bset_pkg::ACT_DISJOINT)
                     || (act_reg == bset_pkg::ACT_EQUAL);
    assign is_write = (act_reg == bset_pkg::ACT_INSERT) || (act_reg == bset_pkg::ACT_DELETE)
                      || (act_reg == bset_pkg::ACT_CLEAR) || is_cb
                      || (act_reg == bset_pkg::ACT_UNION)
                      || (act_reg == bset_pkg::ACT_INTERSECT)
                      || (act_reg == bset_pkg::ACT_DIFFERENCE);

    logic bad_req;
    always_comb
    begin
        case (act_reg)
            bset_pkg::ACT_TEST, bset_pkg::ACT_INSERT, bset_pkg::ACT_DELETE:
                bad_req = (idx_reg >= size);
            bset_pkg::ACT_CLEAR_BELOW:
                bad_req = (idx_reg > size);
            bset_pkg::ACT_ITER_START, bset_pkg::ACT_ITER_NEXT, bset_pkg::ACT_CLEAR,
            bset_pkg::ACT_COUNT, bset_pkg::ACT_EMPTY, bset_pkg::ACT_UNION,
            bset_pkg::ACT_INTERSECT, bset_pkg::ACT_DIFFERENCE,
            bset_pkg::ACT_DISJOINT, bset_pkg::ACT_EQUAL:
                bad_req = 1'b0;
            default:
                bad_req = 1'b1;
        endcase
    end

    // Last word the sweep visits, and the first.
    logic [IW-1:0] end_w, beg_w;
    always_comb
    begin
        beg_w = '0;
        if (is_bit)
        begin
            end_w = wi;
            beg_w = wi;
        end
        else if (is_cb)
        begin
            end_w = (bi == '0) ? wi - IW'(1) : wi;
        end
        else if (is_iter)
        begin
            end_w = last_w;
            beg_w = pwi;
        end
        else
        begin
            end_w = last_w;
        end
    end

    // A clear_below with bound zero, or an iterator past the end, visits nothing.
    logic empty_sweep;
    assign empty_sweep = (is_cb && idx_reg < IW'(WORD_WIDTH)
                          && bi == '0) || (is_iter && ipos_reg >= size);

    assign sts.no_sweep = bad_req || empty_sweep || (act_reg == bset_pkg::ACT_ITER_START);
    assign sts.is_iter  = is_iter;
    assign sts.last_word = cmd.clr_step ? (init_reg == AW'(DEPTH - 1))
                                        : (IW'(w_reg) == end_w);

    logic [AW-1:0] addr_a, addr_b, addr_i;
    assign addr_a = AW'(32'(sa_reg) * WORDS_PER_SET + 32'(w_reg));
    assign addr_b = AW'(32'(sb_reg) * WORDS_PER_SET + 32'(w_reg));
    assign addr_i = AW'(32'(iset_reg) * WORDS_PER_SET + 32'(w_reg));

    // Iterator scan: lowest set bit at or above the start offset.
    logic [BW-1:0]         lo;
    logic [WORD_WIDTH-1:0] scan_w;
    logic [BW-1:0]         hit_pos;
    always_comb
    begin
        lo      = (IW'(w_reg) == pwi) ? pbi : '0;
        scan_w  = da_reg & ({WORD_WIDTH{1'b1}} << lo);
        hit_pos = '0;
        for (int k = WORD_WIDTH - 1; k >= 0; k--)
        begin
            if (scan_w[k])
            begin
                hit_pos = BW'(k);
            end
        end
    end
    assign sts.scan_hit = (scan_w != '0);

    logic [CW-1:0] pop;
    always_comb
    begin
        pop = '0;
        for (int k = 0; k < WORD_WIDTH; k++)
        begin
            pop = pop + CW'(da_reg[k]);
        end
    end

    logic [WORD_WIDTH-1:0] bit_m, low_m, new_w;
    logic                  wr_en;
    always_comb
    begin
        bit_m = {{(WORD_WIDTH-1){1'b0}}, 1'b1} << bi;
        low_m = (IW'(w_reg) == wi) ? (bit_m - 1'b1) : '1;
        new_w = da_reg;
        case (act_reg)
            bset_pkg::ACT_INSERT:      new_w = da_reg | bit_m;
            bset_pkg::ACT_DELETE:      new_w = da_reg & ~bit_m;
            bset_pkg::ACT_CLEAR:       new_w = '0;
            bset_pkg::ACT_CLEAR_BELOW: new_w = da_reg & ~low_m;
            bset_pkg::ACT_UNION:       new_w = da_reg | db_reg;
            bset_pkg::ACT_INTERSECT:   new_w = da_reg & db_reg;
            bset_pkg::ACT_DIFFERENCE:  new_w = da_reg & ~db_reg;
            default:                   new_w = da_reg;
        endcase
        wr_en = cmd.proc && is_write;
    end

    // Memory: one write port and two registered read ports, one for set A or the
    // iterator set and one for set B, so both words are ready in the process step.
    logic [AW-1:0] rd_addr;
    assign rd_addr = is_iter ? addr_i : addr_a;
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[init_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr_a] <= new_w;
        end
        if (cmd.rd)
        begin
            da_reg <= mem[rd_addr];
        end
        if (cmd.rd && is_pair)
        begin
            db_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= bset_pkg::CFG_W'(16);
            init_reg   <= '0;
            iset_reg   <= '0;
            ipos_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                init_reg <= init_reg + AW'(1);
            end
            if (cmd.finish && !bad_req)
            begin
                if (act_reg == bset_pkg::ACT_ITER_START)
                begin
                    iset_reg <= sa_reg;
                    ipos_reg <= '0;
                end
                else if (is_iter)
                begin
                    ipos_reg <= flag_reg ? val_reg + IW'(1) : '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            sa_reg  <= SW'(set_a % 4'(SET_COUNT));
            sb_reg  <= SW'(set_b % 4'(SET_COUNT));
            idx_reg <= bit_index;
            w_reg   <= '0;
            val_reg <= '0;
            flag_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else if (sts.no_sweep && !cmd.proc && !cmd.rd && !cmd.finish && !cmd.clr_step
                 && !done_reg)
        begin
            // Decode cycle.
            err_reg  <= bad_req;
            flag_reg <= 1'b0;
        end
        else if (!cmd.rd && !cmd.proc && !cmd.finish && !cmd.clr_step)
        begin
            w_reg    <= WW'(beg_w);
            flag_reg <= (act_reg == bset_pkg::ACT_EMPTY) || (act_reg == bset_pkg::ACT_DISJOINT)
                        || (act_reg == bset_pkg::ACT_EQUAL);
        end
        if (cmd.proc)
        begin
            case (act_reg)
                bset_pkg::ACT_TEST:
                    flag_reg <= da_reg[bi];
                bset_pkg::ACT_COUNT:
                    val_reg <= val_reg + IW'(pop);
                bset_pkg::ACT_EMPTY:
                    if (da_reg != '0) flag_reg <= 1'b0;
                bset_pkg::ACT_DISJOINT:
                    if ((da_reg & db_reg) != '0) flag_reg <= 1'b0;
                bset_pkg::ACT_EQUAL:
                    if ((da_reg ^ db_reg) != '0) flag_reg <= 1'b0;
                bset_pkg::ACT_ITER_NEXT:
                    if (sts.scan_hit)
                    begin
                        flag_reg <= 1'b1;
                        val_reg  <= IW'({w_reg, hit_pos});
                    end
                default:
                    flag_reg <= flag_reg;
            endcase
            if (cmd.advance)
            begin
                w_reg <= w_reg + WW'(1);
            end
        end
    end

    assign done  = done_reg;
    assign flag  = flag_reg;
    assign value = val_reg;
    assign error = err_reg;

endmodule

// ===== hw/rtl/bitset_set_engine.sv =====
// Requests that touch no memory pass from decode straight to the done state; others
// first read and then process each word they visit, one word after the other.
// Throughput is one request at a time; each word is read in the read state and then
// processed in the process state. done pulses for one cycle and cannot be stalled.
// After reset a clearing pass zeroes all SET_COUNT*WORDS_PER_SET words while busy
// stays high; the active word count (active_reg) resets to 16.
module bitset_set_engine #(
    parameter int WORD_WIDTH    = bset_pkg::WORD_WIDTH_DEF,
    parameter int WORDS_PER_SET = bset_pkg::WORDS_PER_SET_DEF,
    parameter int SET_COUNT     = bset_pkg::SET_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [bset_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [bset_pkg::ACTION_W-1:0] action,
    input  logic [1:0]                    set_a,
    input  logic [1:0]                    set_b,
    input  logic [bset_pkg::INDEX_W-1:0]  bit_index,
    output logic                          done,
    output logic                          flag,
    output logic [bset_pkg::INDEX_W-1:0]  value,
    output logic                          error
);

    bset_pkg::bset_cmd_t cmd;
    bset_pkg::bset_sts_t sts;

    bset_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bset_dp #(
        .WORD_WIDTH    (WORD_WIDTH),
        .WORDS_PER_SET (WORDS_PER_SET),
        .SET_COUNT     (SET_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .action    (action),
        .set_a     (set_a),
        .set_b     (set_b),
        .bit_index (bit_index),
        .done      (done),
        .flag      (flag),
        .value     (value),
        .error     (error)
    );

endmodule
